@@ rtl/core/etlc_pkg.sv @@
package etlc_pkg;

    localparam int EpochW = 31;
    localparam int ZoneW  = 18;
    localparam int TimeW  = 33;
    localparam int DayW   = 17;

    localparam logic [ZoneW-1:0] ZoneReset = 18'h3FFC4;
    localparam logic             DstReset  = 1'b1;

    localparam logic [0:0] CfgZone = 1'b0;
    localparam logic [0:0] CfgDst  = 1'b1;

    localparam logic [11:0] DstShift   = 12'd3600;
    localparam logic [8:0]  BeginDay   = 9'd89;
    localparam logic [8:0]  EndDay     = 9'd272;
    localparam logic [8:0]  LeapShift  = 9'd58;

    // day split: t / 86400 = (t >> 7) / 675, reciprocal ceil(2^36 / 675)
    localparam logic [26:0] DayRecip    = 27'd101806633;
    localparam logic [9:0]  DayOdd      = 10'd675;
    // hour: (r >> 4) / 225, reciprocal ceil(2^21 / 225)
    localparam logic [13:0] HourRecip   = 14'd9321;
    localparam logic [11:0] SecsPerHour = 12'd3600;
    // minute: (s >> 2) / 15, reciprocal ceil(2^14 / 15)
    localparam logic [10:0] MinRecip    = 11'd1093;
    localparam logic [5:0]  SecsPerMin  = 6'd60;
    // modulo 7 for 17-bit values, reciprocal ceil(2^20 / 7)
    localparam logic [17:0] Mod7Recip   = 18'd149797;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVDAY,
        ST_HMS,
        ST_HOUR,
        ST_MINSEC,
        ST_YEAR,
        ST_MONTH,
        ST_SUN_B,
        ST_SUN_E,
        ST_DSTCHK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic hms;
        logic hour_step;
        logic min_step;
        logic year_step;
        logic month_step;
        logic sun_begin;
        logic sun_end;
        logic dst_apply;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
        logic in_window;
    } status_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        begin
            case (m)
                4'd1: r = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
                default: r = 5'd31;
            endcase
            return r;
        end
    endfunction

    function automatic logic [2:0] mod7(input logic [16:0] x);
        logic [34:0] p;
        logic [14:0] q;
        logic [16:0] r;
        begin
            p = 35'(x) * 35'(Mod7Recip);
            q = p[34:20];
            r = x - 17'(q) * 17'd7;
            return r[2:0];
        end
    endfunction

endpackage

@@ rtl/core/etlc_datapath.sv @@
module etlc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  etlc_pkg::cmd_t                cmd,
    output etlc_pkg::status_t             status,
    input  logic [etlc_pkg::EpochW-1:0]   epoch_seconds,
    input  logic [etlc_pkg::ZoneW-1:0]    zone_reg,
    output logic [5:0]                    second,
    output logic [5:0]                    minute,
    output logic [4:0]                    hour,
    output logic [4:0]                    day_of_month,
    output logic [3:0]                    month,
    output logic [7:0]                    years_since_1900,
    output logic [2:0]                    weekday,
    output logic [8:0]                    day_of_year,
    output logic                          dst_active
);

    localparam int TW = etlc_pkg::TimeW;
    localparam int DW = etlc_pkg::DayW;

    logic [TW-1:0]  t_reg;
    logic [52:0]    prod_reg;
    logic [DW-1:0]  days_reg;
    logic [16:0]    drem_reg;
    logic [11:0]    shr_reg;
    logic [5:0]     sec_reg, min_reg;
    logic [4:0]     hour_reg;
    logic [2:0]     wday_reg;
    logic [2:0]     first_reg;
    logic [7:0]     year_reg;
    logic [8:0]     yday_reg;
    logic [3:0]     mon_reg;
    logic [8:0]     mday_reg;
    logic [8:0]     begin_reg, end_reg;
    logic           dst_reg;

    logic signed [TW:0] local_s;
    logic [DW-1:0]  dq;
    logic [25:0]    dlow;
    logic [26:0]    hprod;
    logic [5:0]     hq;
    logic [16:0]    hrem;
    logic [20:0]    mprod;
    logic [6:0]     mq;
    logic [11:0]    mrem;
    logic           leap;
    logic [8:0]     ylen;
    logic [4:0]     mlen;
    logic [8:0]     first_d;
    logic [8:0]     sun_d;
    logic [8:0]     sun_res;
    logic [8:0]     diffm;
    logic           after_b, before_e;

    assign local_s = $signed({{(TW+1-etlc_pkg::EpochW){1'b0}}, epoch_seconds})
                   - $signed({{(TW+1-etlc_pkg::ZoneW){zone_reg[etlc_pkg::ZoneW-1]}}, zone_reg});
    assign dq    = prod_reg[52:36];
    assign dlow  = t_reg[TW-1:7] - 26'(dq) * 26'(etlc_pkg::DayOdd);
    assign hprod = 27'(drem_reg[16:4]) * 27'(etlc_pkg::HourRecip);
    assign hq    = hprod[26:21];
    assign hrem  = drem_reg - 17'(hq) * 17'(etlc_pkg::SecsPerHour);
    assign mprod = 21'(shr_reg[11:2]) * 21'(etlc_pkg::MinRecip);
    assign mq    = mprod[20:14];
    assign mrem  = shr_reg - 12'(mq) * 12'(etlc_pkg::SecsPerMin);
    assign leap = (year_reg[1:0] == 2'b00);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = etlc_pkg::month_len(mon_reg, leap);
    assign first_d = 9'(first_reg);
    assign sun_d = (cmd.sun_begin ? etlc_pkg::BeginDay : etlc_pkg::EndDay)
                 + 9'(leap);
    assign diffm = 9'(etlc_pkg::mod7(17'(sun_d - first_d)));
    assign sun_res = (sun_d < first_d) ? first_d : sun_d - diffm;
    assign after_b = (yday_reg > begin_reg) || (yday_reg == begin_reg && hour_reg >= 5'd2);
    assign before_e = (yday_reg < end_reg) || (yday_reg == end_reg && hour_reg < 5'd3);

    assign status.year_done  = (days_reg < {8'd0, ylen});
    assign status.month_done = (mday_reg < 9'(mlen)) || (mon_reg == 4'd11);
    assign status.in_window  = after_b && before_e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg     <= '0;
            prod_reg  <= '0;
            days_reg  <= '0;
            drem_reg  <= '0;
            shr_reg   <= '0;
            sec_reg   <= '0;
            min_reg   <= '0;
            hour_reg  <= '0;
            wday_reg  <= '0;
            first_reg <= '0;
            year_reg  <= '0;
            yday_reg  <= '0;
            mon_reg   <= '0;
            mday_reg  <= '0;
            begin_reg <= '0;
            end_reg   <= '0;
            dst_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                t_reg   <= local_s[TW] ? '0 : local_s[TW-1:0];
                dst_reg <= 1'b0;
            end
            if (cmd.dst_apply)
            begin
                t_reg   <= t_reg + TW'(etlc_pkg::DstShift);
                dst_reg <= 1'b1;
            end
            if (cmd.div_step)
                prod_reg <= {27'd0, t_reg[TW-1:7]} * {26'd0, etlc_pkg::DayRecip};
            if (cmd.hms)
            begin
                days_reg <= dq;
                drem_reg <= {dlow[9:0], t_reg[6:0]};
                year_reg <= 8'd70;
            end
            if (cmd.hour_step)
            begin
                hour_reg <= hq[4:0];
                shr_reg  <= hrem[11:0];
                wday_reg <= etlc_pkg::mod7(days_reg + 17'd4);
            end
            if (cmd.min_step)
            begin
                min_reg <= mq[5:0];
                sec_reg <= mrem[5:0];
            end
            if (cmd.year_step)
            begin
                if (status.year_done)
                begin
                    yday_reg <= days_reg[8:0];
                    mday_reg <= days_reg[8:0];
                    mon_reg  <= '0;
                end
                else
                begin
                    days_reg <= days_reg - 17'(ylen);
                    year_reg <= year_reg + 8'd1;
                end
            end
            if (cmd.month_step)
                first_reg <= etlc_pkg::mod7(17'(yday_reg) + 17'd420 - 17'(wday_reg));
            if (cmd.month_step && !status.month_done)
            begin
                mday_reg <= mday_reg - 9'(mlen);
                mon_reg  <= mon_reg + 4'd1;
            end
            if (cmd.sun_begin)
                begin_reg <= sun_res;
            if (cmd.sun_end)
                end_reg <= sun_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            second           <= sec_reg;
            minute           <= min_reg;
            hour             <= hour_reg;
            day_of_month     <= 5'(mday_reg + 9'd1);
            month            <= mon_reg;
            years_since_1900 <= year_reg;
            weekday          <= wday_reg;
            day_of_year      <= yday_reg;
            dst_active       <= dst_reg;
        end
    end

endmodule

@@ rtl/core/etlc_ctrl.sv @@
module etlc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  logic              dst_en,
    input  etlc_pkg::status_t status,
    output etlc_pkg::cmd_t    cmd
);

    etlc_pkg::state_t state_reg, state_next;
    logic pass_reg, pass_next;
    logic ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= etlc_pkg::ST_IDLE;
            pass_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign in_stall  = (state_reg != etlc_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        case (state_reg)
            etlc_pkg::ST_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pass_next  = 1'b0;
                    state_next = etlc_pkg::ST_DIVDAY;
                end
            etlc_pkg::ST_DIVDAY:
            begin
                cmd.div_step = 1'b1;
                state_next   = etlc_pkg::ST_HMS;
            end
            etlc_pkg::ST_HMS:
            begin
                cmd.hms    = 1'b1;
                state_next = etlc_pkg::ST_HOUR;
            end
            etlc_pkg::ST_HOUR:
            begin
                cmd.hour_step = 1'b1;
                state_next    = etlc_pkg::ST_MINSEC;
            end
            etlc_pkg::ST_MINSEC:
            begin
                cmd.min_step = 1'b1;
                state_next   = etlc_pkg::ST_YEAR;
            end
            etlc_pkg::ST_YEAR:
            begin
                cmd.year_step = 1'b1;
                if (status.year_done)
                    state_next = etlc_pkg::ST_MONTH;
            end
            etlc_pkg::ST_MONTH:
            begin
                cmd.month_step = 1'b1;
                if (status.month_done)
                    state_next = (dst_en && !pass_reg) ? etlc_pkg::ST_SUN_B
                                                       : etlc_pkg::ST_OUT;
            end
            etlc_pkg::ST_SUN_B:
            begin
                cmd.sun_begin = 1'b1;
                state_next    = etlc_pkg::ST_SUN_E;
            end
            etlc_pkg::ST_SUN_E:
            begin
                cmd.sun_end = 1'b1;
                state_next  = etlc_pkg::ST_DSTCHK;
            end
            etlc_pkg::ST_DSTCHK:
                if (status.in_window)
                begin
                    cmd.dst_apply = 1'b1;
                    pass_next     = 1'b1;
                    state_next    = etlc_pkg::ST_DIVDAY;
                end
                else
                    state_next = etlc_pkg::ST_OUT;
            etlc_pkg::ST_OUT:
                if (!ov_reg || !out_stall)
                begin
                    cmd.capture = 1'b1;
                    ov_next     = 1'b1;
                    state_next  = etlc_pkg::ST_IDLE;
                end
            default:
                state_next = etlc_pkg::ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> out_valid)
        else $error("capture without valid");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dst_apply |-> !pass_reg)
        else $error("dst applied twice");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd.capture)
        else $error("result overwritten");

endmodule

@@ rtl/core/epoch_to_local_calendar_core.sv @@
// The conversion steps through the years past 1970 and the months into the year, and
// adds the DST checks when DST is enabled; a DST hour reruns the split.
// Throughput: one item at a time; the next item is taken the cycle after the result is
// registered. The result register holds while stalled.
// Reset (rst_n, async low) clears control; zone offset resets to -60, DST enabled.
module epoch_to_local_calendar_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [etlc_pkg::ZoneW-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [etlc_pkg::EpochW-1:0] epoch_seconds,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [5:0]                  second,
    output logic [5:0]                  minute,
    output logic [4:0]                  hour,
    output logic [4:0]                  day_of_month,
    output logic [3:0]                  month,
    output logic [7:0]                  years_since_1900,
    output logic [2:0]                  weekday,
    output logic [8:0]                  day_of_year,
    output logic                        dst_active
);

    logic [etlc_pkg::ZoneW-1:0] zone_reg;
    logic                       dst_en_reg;
    etlc_pkg::cmd_t             cmd;
    etlc_pkg::status_t          status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg   <= etlc_pkg::ZoneReset;
            dst_en_reg <= etlc_pkg::DstReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                etlc_pkg::CfgZone: zone_reg   <= cfg_data;
                etlc_pkg::CfgDst:  dst_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    etlc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dst_en    (dst_en_reg),
        .status    (status),
        .cmd       (cmd)
    );

    etlc_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .epoch_seconds    (epoch_seconds),
        .zone_reg         (zone_reg),
        .second           (second),
        .minute           (minute),
        .hour             (hour),
        .day_of_month     (day_of_month),
        .month            (month),
        .years_since_1900 (years_since_1900),
        .weekday          (weekday),
        .day_of_year      (day_of_year),
        .dst_active       (dst_active)
    );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] mins;
        logic [4:0] hr;
        logic [4:0] mday;
        logic [3:0] mon;
        logic [7:0] yr;
        logic [2:0] wday;
        logic [8:0] yday;
        logic       dst;
    } cal_beat_t;

    typedef struct {
        logic [30:0] epoch;
        logic        check;
        cal_beat_t   want;
    } row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [0:0]                  cfg_index;
    logic [etlc_pkg::ZoneW-1:0]  cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic [etlc_pkg::EpochW-1:0] epoch_seconds;
    logic                        out_valid;
    logic                        out_stall;
    logic [5:0]                  second;
    logic [5:0]                  minute;
    logic [4:0]                  hour;
    logic [4:0]                  day_of_month;
    logic [3:0]                  month;
    logic [7:0]                  years_since_1900;
    logic [2:0]                  weekday;
    logic [8:0]                  day_of_year;
    logic                        dst_active;

    logic [etlc_pkg::ZoneW-1:0]  zone_model;
    logic                        dst_model;
    cal_beat_t         pending_dates[$];
    int                errors;
    int                results_seen;
    int                dst_seen;
    bit                calm;
    bit                hold_req;
    int                hold_count;
    int                stall_left;

    epoch_to_local_calendar_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .epoch_seconds(epoch_seconds), .out_valid(out_valid), .out_stall(out_stall),
        .second(second), .minute(minute), .hour(hour), .day_of_month(day_of_month),
        .month(month), .years_since_1900(years_since_1900), .weekday(weekday),
        .day_of_year(day_of_year), .dst_active(dst_active)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned year_days(int unsigned y);
        return (y % 4 == 0) ? 366 : 365;
    endfunction

    function automatic cal_beat_t split_calendar(longint unsigned t);
        cal_beat_t c;
        longint unsigned days;
        int unsigned rem;
        int unsigned y;
        int unsigned m;
        int unsigned len;
        int unsigned mlen[12];
        mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        days = t / 86400;
        rem = 32'(t % 86400);
        y = 1970;
        m = 0;
        c.sec = 6'(rem % 60);
        c.mins = 6'((rem % 3600) / 60);
        c.hr = 5'(rem / 3600);
        c.wday = 3'((days + 4) % 7);
        while (days >= year_days(y))
        begin
            days -= year_days(y);
            y++;
        end
        c.yr = 8'(y - 1900);
        c.yday = 9'(days);
        forever
        begin
            len = mlen[m];
            if (m == 1 && year_days(y) == 366)
                len = 29;
            if (days < len || m == 11)
                break;
            days -= len;
            m++;
        end
        c.mday = 5'(days + 1);
        c.mon = 4'(m);
        c.dst = 1'b0;
        return c;
    endfunction

    function automatic int unsigned final_sunday_day(int unsigned d, cal_beat_t c);
        int unsigned first;
        first = (c.yday + 420 - c.wday) % 7;
        if (d >= 58 && c.yr % 4 == 0)
            d++;
        if (d < first)
            return first;
        return d - (d - first) % 7;
    endfunction

    function automatic cal_beat_t local_date(logic [30:0] epoch);
        cal_beat_t c;
        longint lt;
        int unsigned b;
        int unsigned e;
        bit after_b;
        bit before_e;
        lt = longint'(epoch) - longint'(signed'(zone_model));
        if (lt < 0)
            lt = 0;
        c = split_calendar(lt);
        if (dst_model)
        begin
            b = final_sunday_day(89, c);
            e = final_sunday_day(272, c);
            after_b = c.yday > b || (c.yday == b && c.hr >= 2);
            before_e = c.yday < e || (c.yday == e && c.hr < 3);
            if (after_b && before_e)
            begin
                c = split_calendar(lt + 3600);
                c.dst = 1'b1;
            end
        end
        return c;
    endfunction

    task automatic write_reg(logic [0:0] idx, logic [etlc_pkg::ZoneW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == etlc_pkg::CfgZone)
            zone_model = val;
        else
            dst_model = val[0];
        @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic send_epoch(logic [30:0] e, bit chk, cal_beat_t w);
        cal_beat_t p;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        epoch_seconds <= e;
        p = local_date(e);
        if (chk && p != w)
        begin
            $display("%0t table row %h: expected %h, actual %h", $time, e, w, p);
            errors++;
        end
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_dates.push_back(p);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t unexpected beat %h", $time,
                    {second, minute, hour, day_of_month, month, years_since_1900,
                     weekday, day_of_year, dst_active});
                errors++;
            end
            else
            begin
                cal_beat_t w;
                cal_beat_t a;
                w = pending_dates.pop_front();
                a = '{second, minute, hour, day_of_month, month, years_since_1900,
                      weekday, day_of_year, dst_active};
                if (a.sec != w.sec || a.mins != w.mins || a.hr != w.hr
                    || a.mday != w.mday || a.mon != w.mon || a.yr != w.yr
                    || a.wday != w.wday || a.yday != w.yday || a.dst != w.dst)
                begin
                    $display("%0t mismatch: expected %p, actual %p", $time, w, a);
                    errors++;
                end
                results_seen++;
                dst_seen += a.dst;
            end
        end
    end

    // receiver stall bursts plus one long hold
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_count <= 0;
            stall_left <= 0;
        end
        else if (hold_req && hold_count < 600)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!out_stall && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("epoch_to_local_calendar_core regression: fail");
        $finish;
    end

    initial
    begin
        row_t rows[$];
        cal_beat_t z;
        logic [17:0] zones[6];
        logic [30:0] e;
        int unsigned yrs;
        z = '0;
        zones = '{18'h3FFC4, 18'h0, 18'd86400, -18'sd86400, 18'h1FFFF, 18'h20000};
        errors = 0;
        results_seen = 0;
        dst_seen = 0;
        calm = 0;
        hold_req = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = etlc_pkg::CfgZone;
        cfg_data = '0;
        in_valid = 1'b0;
        epoch_seconds = '0;
        zone_model = etlc_pkg::ZoneReset;
        dst_model = etlc_pkg::DstReset;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // epoch 0 with zone -60: 00:01:00 Thursday 1 Jan 1970
        rows.push_back('{31'd0, 1'b1, '{6'd0, 6'd1, 5'd0, 5'd1, 4'd0, 8'd70,
                                       3'd4, 9'd0, 1'b0}});
        rows.push_back('{31'h7FFFFFFF, 1'b0, z});
        rows.push_back('{31'h55555555, 1'b0, z});
        rows.push_back('{31'h2AAAAAAA, 1'b0, z});
        rows.push_back('{31'd68169540, 1'b0, z});
        rows.push_back('{31'd68173140, 1'b0, z});
        rows.push_back('{31'd86399, 1'b0, z});
        rows.push_back('{31'd951782400, 1'b0, z});
        rows.push_back('{31'd1710000000, 1'b0, z});
        foreach (rows[i])
            send_epoch(rows[i].epoch, rows[i].check, rows[i].want);
        drain();

        // negative local time saturates to the epoch
        write_reg(etlc_pkg::CfgZone, 18'd86400);
        write_reg(etlc_pkg::CfgDst, 18'd0);
        send_epoch(31'd100, 1'b1, '{6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 8'd70, 3'd4, 9'd0, 1'b0});
        send_epoch(31'd0, 1'b1, '{6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 8'd70, 3'd4, 9'd0, 1'b0});
        drain();

        hold_req = 1;
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(etlc_pkg::CfgZone, ph < 6 ? zones[ph] : 18'($urandom));
            write_reg(etlc_pkg::CfgDst, 18'(ph % 2 == 0));
            if (ph == 11)
                calm = 1;
            for (int k = 0; k < 87; k++)
            begin
                case ($urandom_range(0, 3))
                    0: e = 31'($urandom);
                    1: e = 31'($urandom_range(0, 200000));
                    default:
                    begin
                        // near the spring and autumn switch days
                        yrs = $urandom_range(0, 67);
                        e = 31'(yrs * 31557600 + ($urandom_range(0, 1) ? 84 : 265) * 86400
                              + $urandom_range(0, 14 * 86400));
                    end
                endcase
                send_epoch(e, 1'b0, z);
                if (k == 40)
                    drain();
            end
            drain();
        end
        repeat (300) @(posedge clk);

        $display("covered %0d conversions over 12 zone/DST settings, %0d with DST hour",
                 results_seen, dst_seen);
        if (errors == 0 && pending_dates.size() == 0)
            $display("epoch_to_local_calendar_core regression: pass");
        else
            $display("epoch_to_local_calendar_core regression: fail");
        $finish;
    end

endmodule

@@ epoch_to_local_calendar_core.f @@
rtl/core/etlc_pkg.sv
rtl/core/etlc_datapath.sv
rtl/core/etlc_ctrl.sv
rtl/core/epoch_to_local_calendar_core.sv
dv/tb_top.sv
